/* rtl/core/lpfr_pkg.sv */
// ----------------------------------------------------------------------------
// lpfr_pkg: shared types and constants for the length-prefixed frame receiver
// Phase and result-kind codes, item and result structs, framing constants.
// ----------------------------------------------------------------------------
package lpfr_pkg;

	localparam int LENGTH_FIELD_BYTES = 4;
	localparam int LEN_IDX_W          = 2;

	localparam logic [7:0]  FLAG_BYTE      = 8'hC0;
	localparam logic [31:0] MIN_TOTAL_LEN  = 32'd10;
	localparam logic [30:0] FRAME_OVERHEAD = 31'd6;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_SKIP    = 3'd1,
		PH_LEN     = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_TRAILER = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		KIND_BYTE    = 3'd0,
		KIND_GOOD    = 3'd1,
		KIND_SHORT   = 3'd2,
		KIND_TRAILER = 3'd3,
		KIND_ENDED   = 3'd4
	} kind_t;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [30:0] payload_length;
	} result_t;

endpackage

/* rtl/core/length_prefixed_frame_receiver.sv */
// A byte accepted into the input register passes the combinational deframer step, and
// any result goes into the result register. Throughput: one transaction per cycle,
// sustained while the output is not stalled, through the input and result registers.
// A stalled output holds its result and stalls the input register behind it.
// Reset (arst_n low, asynchronous): phase returns to hunting, counters clear,
// both registers empty.
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver: deframer top level
// Input register, deframer state machine, result register.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver #(
	parameter int LENGTH_FIELD_BYTES = lpfr_pkg::LENGTH_FIELD_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [30:0] payload_length
);

	lpfr_pkg::item_t   item_in;
	lpfr_pkg::item_t   item_s1;
	logic              valid_s1;
	logic              advance;
	logic              out_free;
	logic              res_valid;
	lpfr_pkg::result_t res;
	lpfr_pkg::result_t res_q;

	assign item_in.func      = func;
	assign item_in.data_byte = data_byte;

	// step only when the result register can take whatever comes out
	assign advance = valid_s1 && out_free;

	lpfr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (in_valid),
		.ready    (in_ready),
		.item     (item_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	lpfr_deframer #(
		.LENGTH_FIELD_BYTES (LENGTH_FIELD_BYTES)
	) u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	lpfr_out_stage u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && res_valid),
		.res    (res),
		.free   (out_free),
		.valid  (out_valid),
		.ready  (out_ready),
		.res_q  (res_q)
	);

	assign kind           = res_q.kind;
	assign payload_byte   = res_q.payload_byte;
	assign payload_length = res_q.payload_length;

`ifndef SYNTHESIS
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != lpfr_pkg::KIND_BYTE |-> payload_byte == 8'd0)
		else $error("payload_byte set on a status transaction");

	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != lpfr_pkg::KIND_GOOD |-> payload_length == 31'd0)
		else $error("payload_length set on a non-good transaction");

	a_good_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == lpfr_pkg::KIND_GOOD |-> payload_length >= 31'd4)
		else $error("good frame with impossible payload length");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pending result lost under backpressure");
`endif

endmodule

/* rtl/core/lpfr_in_stage.sv */
// ----------------------------------------------------------------------------
// lpfr_in_stage: input register
// Captures one transaction per cycle unless the deframer stalls; holds it until the deframer consumes it.
// ----------------------------------------------------------------------------
module lpfr_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	output logic            ready,
	input  lpfr_pkg::item_t item,
	input  logic            advance,
	output logic            valid_s1,
	output lpfr_pkg::item_t item_s1
);

	assign ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (valid && ready) begin
			item_s1 <= item;
		end
	end

endmodule

/* rtl/core/lpfr_deframer.sv */
// ----------------------------------------------------------------------------
// lpfr_deframer: frame state machine and length datapath
// Tracks phase, gathers the little-endian length, counts payload bytes.
// ----------------------------------------------------------------------------
module lpfr_deframer #(
	parameter int LENGTH_FIELD_BYTES = lpfr_pkg::LENGTH_FIELD_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  lpfr_pkg::item_t   item,
	output logic              res_valid,
	output lpfr_pkg::result_t res
);

	localparam logic [lpfr_pkg::LEN_IDX_W-1:0] IDX_LAST =
		lpfr_pkg::LEN_IDX_W'(LENGTH_FIELD_BYTES - 1);

	lpfr_pkg::phase_t                 phase_q, phase_d;
	logic [31:0]                      accum_q, accum_d;
	logic [lpfr_pkg::LEN_IDX_W-1:0]   idx_q, idx_d;
	logic [30:0]                      remaining_q, remaining_d;
	logic [30:0]                      total_q, total_d;

	logic                             is_flag;
	logic [31:0]                      accum_base;
	logic [31:0]                      accum_new;
	logic [lpfr_pkg::LEN_IDX_W-1:0]   idx_eff;
	logic                             len_last;
	logic                             len_short;
	logic [30:0]                      len_payload;
	logic [30:0]                      rem_dec;

	// length byte lands at its byte lane; skip phase restarts the field
	always_comb begin
		is_flag     = item.data_byte == lpfr_pkg::FLAG_BYTE;
		accum_base  = (phase_q == lpfr_pkg::PH_SKIP) ? 32'd0 : accum_q;
		idx_eff     = (phase_q == lpfr_pkg::PH_SKIP) ? '0 : idx_q;
		accum_new   = accum_base | ({24'd0, item.data_byte} << {idx_eff, 3'b000});
		len_last    = idx_eff == IDX_LAST;
		len_short   = accum_new[31] || (accum_new < lpfr_pkg::MIN_TOTAL_LEN);
		len_payload = accum_new[30:0] - lpfr_pkg::FRAME_OVERHEAD;
		rem_dec     = remaining_q - 31'd1;
	end

	// next state
	always_comb begin
		phase_d     = phase_q;
		accum_d     = accum_q;
		idx_d       = idx_q;
		remaining_d = remaining_q;
		total_d     = total_q;
		if (item.func) begin
			phase_d = lpfr_pkg::PH_HUNT;
			idx_d   = '0;
		end else begin
			unique case (phase_q)
				lpfr_pkg::PH_SKIP, lpfr_pkg::PH_LEN: begin
					if (!(phase_q == lpfr_pkg::PH_SKIP && is_flag)) begin
						accum_d = accum_new;
						if (len_last) begin
							idx_d = '0;
							if (len_short) begin
								phase_d = lpfr_pkg::PH_HUNT;
							end else begin
								phase_d     = lpfr_pkg::PH_PAYLOAD;
								total_d     = len_payload;
								remaining_d = len_payload;
							end
						end else begin
							idx_d   = idx_eff + 1'b1;
							phase_d = lpfr_pkg::PH_LEN;
						end
					end
				end
				lpfr_pkg::PH_PAYLOAD: begin
					remaining_d = rem_dec;
					if (rem_dec == 31'd0) begin
						phase_d = lpfr_pkg::PH_TRAILER;
					end
				end
				lpfr_pkg::PH_TRAILER: begin
					phase_d = lpfr_pkg::PH_HUNT;
				end
				// hunting, and any meaningless phase code
				default: begin
					phase_d = is_flag ? lpfr_pkg::PH_SKIP : lpfr_pkg::PH_HUNT;
				end
			endcase
		end
	end

	// result
	always_comb begin
		res_valid          = 1'b0;
		res.kind           = lpfr_pkg::KIND_BYTE;
		res.payload_byte   = 8'd0;
		res.payload_length = 31'd0;
		if (item.func) begin
			res.kind  = lpfr_pkg::KIND_ENDED;
			res_valid = (phase_q == lpfr_pkg::PH_SKIP) || (phase_q == lpfr_pkg::PH_LEN) ||
				(phase_q == lpfr_pkg::PH_PAYLOAD) || (phase_q == lpfr_pkg::PH_TRAILER);
		end else begin
			unique case (phase_q)
				lpfr_pkg::PH_SKIP, lpfr_pkg::PH_LEN: begin
					res.kind  = lpfr_pkg::KIND_SHORT;
					res_valid = !(phase_q == lpfr_pkg::PH_SKIP && is_flag) &&
						len_last && len_short;
				end
				lpfr_pkg::PH_PAYLOAD: begin
					res_valid        = 1'b1;
					res.kind         = lpfr_pkg::KIND_BYTE;
					res.payload_byte = item.data_byte;
				end
				lpfr_pkg::PH_TRAILER: begin
					res_valid = 1'b1;
					if (is_flag) begin
						res.kind           = lpfr_pkg::KIND_GOOD;
						res.payload_length = total_q;
					end else begin
						res.kind = lpfr_pkg::KIND_TRAILER;
					end
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= lpfr_pkg::PH_HUNT;
			accum_q     <= 32'd0;
			idx_q       <= '0;
			remaining_q <= 31'd0;
			total_q     <= 31'd0;
		end else if (fire) begin
			phase_q     <= phase_d;
			accum_q     <= accum_d;
			idx_q       <= idx_d;
			remaining_q <= remaining_d;
			total_q     <= total_d;
		end
	end

endmodule

/* rtl/core/lpfr_out_stage.sv */
// ----------------------------------------------------------------------------
// lpfr_out_stage: result register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module lpfr_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  lpfr_pkg::result_t res,
	output logic              free,
	output logic              valid,
	input  logic              ready,
	output lpfr_pkg::result_t res_q
);

	logic valid_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_q <= res;
		end
	end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for length_prefixed_frame_receiver
// Drives framed byte streams (good frames, short/negative lengths, bad
// trailers, streams cut off mid-frame, noise) under random idling on both
// sides, predicts each result transaction and compares it in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;

	typedef enum int {
		IDLE_NONE,
		IDLE_SOME,
		IDLE_HEAVY
	} idle_mode_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        func;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  kind;
	logic [7:0]  payload_byte;
	logic [30:0] payload_length;

	// deframer prediction state
	lpfr_pkg::phase_t pred_phase;
	logic [31:0]      pred_len_accum;
	logic [1:0]       pred_len_idx;
	logic [30:0]      pred_remaining;
	logic [30:0]      pred_total;

	lpfr_pkg::result_t expected_results[$];
	int                mismatches;
	int                bytes_sent;
	int                cycle_count;
	int                rx_hold_cycles;
	idle_mode_t        tx_idle_mode;
	idle_mode_t        rx_idle_mode;

	length_prefixed_frame_receiver u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.payload_byte   (payload_byte),
		.payload_length (payload_length)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("length_prefixed_frame_receiver: mismatch");
			$finish;
		end
	end

	function automatic int idle_cycles(idle_mode_t mode);
		case (mode)
			IDLE_NONE: return 0;
			IDLE_SOME: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
			default:   return $urandom_range(0, 14);
		endcase
	endfunction

	function automatic idle_mode_t pick_idle_mode();
		case ($urandom_range(0, 2))
			0:       return IDLE_NONE;
			1:       return IDLE_SOME;
			default: return IDLE_HEAVY;
		endcase
	endfunction

	function automatic void report_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0d] %s", cycle_count, what);
	endfunction

	// ---------------- predictor ----------------

	function automatic void push_result(lpfr_pkg::kind_t k, logic [7:0] b, logic [30:0] n);
		lpfr_pkg::result_t r;
		r.kind           = k;
		r.payload_byte   = b;
		r.payload_length = n;
		expected_results.push_back(r);
	endfunction

	function automatic void add_length_byte(logic [7:0] b);
		int idx;
		idx = int'(pred_len_idx);
		pred_len_accum = pred_len_accum | (32'(b) << (8 * idx));
		if (idx + 1 < lpfr_pkg::LENGTH_FIELD_BYTES) begin
			pred_len_idx = 2'(idx + 1);
			pred_phase   = lpfr_pkg::PH_LEN;
			return;
		end
		pred_len_idx = '0;
		if (pred_len_accum[31] || pred_len_accum < lpfr_pkg::MIN_TOTAL_LEN) begin
			pred_phase = lpfr_pkg::PH_HUNT;
			push_result(lpfr_pkg::KIND_SHORT, 8'd0, 31'd0);
		end else begin
			pred_total     = pred_len_accum[30:0] - lpfr_pkg::FRAME_OVERHEAD;
			pred_remaining = pred_total;
			pred_phase     = lpfr_pkg::PH_PAYLOAD;
		end
	endfunction

	function automatic void deframe_step(lpfr_pkg::item_t it);
		lpfr_pkg::phase_t cur;
		cur = pred_phase;
		if (it.func) begin
			pred_phase   = lpfr_pkg::PH_HUNT;
			pred_len_idx = '0;
			if (cur != lpfr_pkg::PH_HUNT)
				push_result(lpfr_pkg::KIND_ENDED, 8'd0, 31'd0);
			return;
		end
		case (cur)
			lpfr_pkg::PH_SKIP: begin
				if (it.data_byte != lpfr_pkg::FLAG_BYTE) begin
					pred_len_accum = '0;
					pred_len_idx   = '0;
					add_length_byte(it.data_byte);
				end
			end
			lpfr_pkg::PH_LEN: add_length_byte(it.data_byte);
			lpfr_pkg::PH_PAYLOAD: begin
				pred_remaining = pred_remaining - 31'd1;
				if (pred_remaining == 31'd0)
					pred_phase = lpfr_pkg::PH_TRAILER;
				push_result(lpfr_pkg::KIND_BYTE, it.data_byte, 31'd0);
			end
			lpfr_pkg::PH_TRAILER: begin
				pred_phase = lpfr_pkg::PH_HUNT;
				if (it.data_byte == lpfr_pkg::FLAG_BYTE)
					push_result(lpfr_pkg::KIND_GOOD, 8'd0, pred_total);
				else
					push_result(lpfr_pkg::KIND_TRAILER, 8'd0, 31'd0);
			end
			default: pred_phase = (it.data_byte == lpfr_pkg::FLAG_BYTE) ?
				lpfr_pkg::PH_SKIP : lpfr_pkg::PH_HUNT;
		endcase
	endfunction

	// ---------------- input side ----------------

	task automatic send_item(lpfr_pkg::item_t it);
		int gap;
		gap = idle_cycles(tx_idle_mode);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		func      <= it.func;
		data_byte <= it.data_byte;
		do @(posedge clk); while (in_ready !== 1'b1);
		deframe_step(it);
		bytes_sent++;
	endtask

	task automatic send_byte(logic [7:0] b);
		send_item({1'b0, b});
	endtask

	task automatic send_end(logic [7:0] junk);
		send_item({1'b1, junk});
	endtask

	task automatic send_length(logic [31:0] total_len);
		for (int i = 0; i < lpfr_pkg::LENGTH_FIELD_BYTES; i++)
			send_byte(total_len[8 * i +: 8]);
	endtask

	// drop valid and wait until every predicted result has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	// ---------------- output side ----------------

	initial begin : result_sink
		int stall;
		out_ready = 1'b0;
		forever begin
			if (rx_hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end
			stall = idle_cycles(rx_idle_mode);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	always @(posedge clk) begin : result_check
		lpfr_pkg::result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind=%0d byte=%02h len=%0d",
					kind, payload_byte, payload_length));
			end else begin
				want = expected_results.pop_front();
				if (kind !== want.kind || payload_byte !== want.payload_byte ||
						payload_length !== want.payload_length)
					report_mismatch($sformatf(
						"exp kind=%0d byte=%02h len=%0d, got kind=%0d byte=%02h len=%0d",
						want.kind, want.payload_byte, want.payload_length,
						kind, payload_byte, payload_length));
			end
		end
	end

	// ---------------- tests ----------------

	task automatic test_directed();
		tx_idle_mode = IDLE_SOME;
		rx_idle_mode = IDLE_SOME;
		send_end(8'hFF);                 // end while hunting: nothing comes out
		send_byte(8'h00);                // noise while hunting
		// good frame, repeated start flag, payload holding flag and extremes
		send_byte(lpfr_pkg::FLAG_BYTE);
		send_byte(lpfr_pkg::FLAG_BYTE);
		send_length(32'd10);
		send_byte(lpfr_pkg::FLAG_BYTE);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h55);
		send_byte(lpfr_pkg::FLAG_BYTE);
		// one below the minimum
		send_byte(lpfr_pkg::FLAG_BYTE);
		send_length(32'd9);
		// negative length
		send_byte(lpfr_pkg::FLAG_BYTE);
		send_length(32'hFFFF_FFFF);
		// stream ends during flag skip, length and payload
		send_byte(lpfr_pkg::FLAG_BYTE);
		send_end(8'h00);
		send_byte(lpfr_pkg::FLAG_BYTE);
		send_byte(8'h01);
		send_end(8'hA5);
		send_byte(lpfr_pkg::FLAG_BYTE);
		send_length(32'h7FFF_FFFF);
		send_byte(8'hAA);
		send_end(8'h5A);
	endtask

	// hold the output off long enough that the block backs up into its input
	task automatic test_output_stall();
		tx_idle_mode   = IDLE_NONE;
		rx_idle_mode   = IDLE_NONE;
		rx_hold_cycles = 120;
		send_byte(lpfr_pkg::FLAG_BYTE);
		send_length(32'd46);
		repeat (40) send_byte(8'($urandom));
		send_byte(lpfr_pkg::FLAG_BYTE);
	endtask

	// sender pauses mid-frame until all results are out, then finishes the frame
	task automatic test_drain_pause();
		tx_idle_mode = IDLE_SOME;
		rx_idle_mode = IDLE_HEAVY;
		send_byte(lpfr_pkg::FLAG_BYTE);
		send_length(32'd16);
		repeat (3) send_byte(8'($urandom));
		wait_drained();
		repeat (7) send_byte(8'($urandom));
		send_byte(8'h3C);                // bad trailer
		send_byte(8'h81);
		send_byte(lpfr_pkg::FLAG_BYTE);
		send_length(32'd10);
		repeat (4) send_byte(8'($urandom));
		send_end(8'($urandom));          // end in trailer phase
	endtask

	task automatic send_random_frame();
		lpfr_pkg::item_t seq[$];
		int              sel;
		int              cut;
		logic [31:0]     total_len;
		logic [7:0]      trailer;
		lpfr_pkg::item_t noise;
		sel = $urandom_range(0, 99);
		if ($urandom_range(0, 4) == 0) begin
			noise.func      = 1'($urandom_range(0, 1));
			noise.data_byte = 8'($urandom);
			if (!noise.func && noise.data_byte == lpfr_pkg::FLAG_BYTE)
				noise.data_byte[0] = 1'b1;
			seq.push_back(noise);
		end
		seq.push_back({1'b0, lpfr_pkg::FLAG_BYTE});
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) seq.push_back({1'b0, lpfr_pkg::FLAG_BYTE});
		if (sel < 8)
			total_len = $urandom_range(0, 1) ? 32'($urandom_range(0, 9)) : {1'b1, 31'($urandom)};
		else if (sel < 12)
			total_len = $urandom_range(10, 400);
		else
			total_len = $urandom_range(10, 40);
		// a first length byte equal to the flag would be skipped
		if (total_len[7:0] == lpfr_pkg::FLAG_BYTE)
			total_len[0] = ~total_len[0];
		for (int i = 0; i < lpfr_pkg::LENGTH_FIELD_BYTES; i++)
			seq.push_back({1'b0, total_len[8 * i +: 8]});
		if (!total_len[31] && total_len >= lpfr_pkg::MIN_TOTAL_LEN) begin
			repeat (int'(total_len) - 6) seq.push_back({1'b0, 8'($urandom)});
			trailer = lpfr_pkg::FLAG_BYTE;
			if (sel >= 12 && sel < 20)
				trailer = 8'($urandom);
			seq.push_back({1'b0, trailer});
		end
		if (sel >= 20 && sel < 30) begin
			cut = $urandom_range(1, seq.size() - 1);
			while (seq.size() > cut)
				void'(seq.pop_back());
			seq.push_back({1'b1, 8'($urandom)});
		end
		foreach (seq[i])
			send_item(seq[i]);
	endtask

	task automatic test_random_stream();
		int stop_at;
		int frames;
		stop_at = bytes_sent + 2000;
		frames  = 0;
		while (bytes_sent < stop_at) begin
			if (frames % 8 == 0) begin
				tx_idle_mode = pick_idle_mode();
				rx_idle_mode = pick_idle_mode();
			end
			send_random_frame();
			frames++;
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		func           = 1'b0;
		data_byte      = 8'd0;
		mismatches     = 0;
		bytes_sent     = 0;
		cycle_count    = 0;
		rx_hold_cycles = 0;
		tx_idle_mode   = IDLE_NONE;
		rx_idle_mode   = IDLE_NONE;
		pred_phase     = lpfr_pkg::PH_HUNT;
		pred_len_accum = '0;
		pred_len_idx   = '0;
		pred_remaining = '0;
		pred_total     = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_output_stall();
		test_drain_pause();
		test_random_stream();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				expected_results.size()));
		if (mismatches == 0)
			$display("length_prefixed_frame_receiver: match");
		else
			$display("length_prefixed_frame_receiver: mismatch");
		$finish;
	end

endmodule
